// ----- hw/rtl/gsnm_pkg.sv -----
package gsnm_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 8'd1;

  // Field widths fixed by the interface.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BIN_W    = 10;
  localparam int unsigned INT_W    = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned SUM_W    = 26;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Input beat.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [BIN_W-1:0]    bin_index;
    logic [INT_W-1:0]    intensity;
    logic [WEIGHT_W-1:0] ref_weight;
    logic                last_sample;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic               match_found;
    logic [ENTRY_W-1:0] best_entry;
    logic [SUM_W-1:0]   best_score;
  } out_t;

  // Decoded item handed from the read stage to the search stage.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              last;
    logic              gate_ok;
  } step_t;

endpackage

// ----- hw/rtl/gated_sad_nearest_match.sv -----
// Spectrum matcher by nearest sum of absolute differences. Load beats write
// the query spectrum into an on-chip bin store; sample beats then read the
// matching query bin and add the absolute difference to a running sum; the
// last sample of each reference applies the weight gate and keeps the lowest
// sum (earliest reference on a tie); a report beat returns the best entry and
// score and clears the search. The block takes one beat per cycle. Each beat
// reads its query bin at the edge that accepts it and is accumulated and
// compared in the following cycle, so a report passes through the read stage
// register and the result register before it is presented on the output, and
// input stalls only while a report waits behind a stalled result.
// Configuration writes are always accepted and apply to beats that follow.
module gated_sad_nearest_match #(
  parameter int unsigned MAX_BINS    = 1024,
  parameter int unsigned MAX_REFS    = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gsnm_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gsnm_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gsnm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gsnm_pkg::WEIGHT_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_BINS);

  logic [gsnm_pkg::WEIGHT_W-1:0] qweight_q;
  logic [gsnm_pkg::WEIGHT_W-1:0] tol_q;

  logic                   in_acc;
  logic                   in_range;
  logic [31:0]            bin_ext;
  logic [AW-1:0]          bin_addr;
  logic [SAMPLE_BITS-1:0] sample;
  logic [gsnm_pkg::WEIGHT_W-1:0] wdiff;
  logic                   ram_we;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] qbin;

  logic                   s1_vld_q, s1_vld_d;
  gsnm_pkg::step_t        s1_step_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_go;
  logic                   out_busy;

  logic                   res_vld;
  gsnm_pkg::out_t         res;
  logic                   out_vld_q;
  gsnm_pkg::out_t         out_data_q;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qweight_q <= '0;
      tol_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gsnm_pkg::CFG_QUERY_WEIGHT: qweight_q <= cfg_data_i;
        gsnm_pkg::CFG_TOLERANCE:    tol_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A report can only leave the search stage when the result slot is free.
  assign out_busy   = out_vld_q && out_stall_i;
  assign s1_go      = s1_vld_q && !(s1_step_q.func == gsnm_pkg::FUNC_REPORT && out_busy);
  assign in_stall_o = s1_vld_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the accepted beat and drive the bin store.
  always_comb begin
    bin_ext  = 32'(in_data_i.bin_index);
    bin_addr = bin_ext[AW-1:0];
    in_range = bin_ext < 32'(MAX_BINS);
    sample   = SAMPLE_BITS'(in_data_i.intensity);
    wdiff    = (in_data_i.ref_weight > qweight_q) ? (in_data_i.ref_weight - qweight_q)
                                                  : (qweight_q - in_data_i.ref_weight);
    ram_we   = in_acc && in_data_i.func == gsnm_pkg::FUNC_LOAD && in_range;
    ram_re   = in_acc && in_data_i.func == gsnm_pkg::FUNC_SAMPLE && in_range;
  end

  gsnm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_addr),
    .wdata_i (sample),
    .re_i    (ram_re),
    .raddr_i (bin_addr),
    .rdata_o (qbin)
  );

  // Read stage register, aligned with the bin-store read data.
  assign s1_vld_d = in_acc || (s1_vld_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_step_q.func     <= in_data_i.func;
      s1_step_q.in_range <= in_range;
      s1_step_q.last     <= in_data_i.last_sample;
      s1_step_q.gate_ok  <= wdiff <= tol_q;
      s1_sample_q        <= sample;
    end
  end

  gsnm_search #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_REFS    (MAX_REFS)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (s1_go),
    .step_i    (s1_step_q),
    .sample_i  (s1_sample_q),
    .qbin_i    (qbin),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/gsnm_ram.sv -----
module gsnm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gsnm_search.sv -----
module gsnm_search #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_REFS    = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  gsnm_pkg::step_t        step_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] qbin_i,
  output logic                   res_vld_o,
  output gsnm_pkg::out_t         res_o
);

  localparam int unsigned CW = $clog2(MAX_REFS + 1);
  localparam int unsigned SW = gsnm_pkg::SUM_W;

  logic [SW-1:0] run_q, run_d;
  logic [SW-1:0] best_q, best_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          found_q, found_d;

  logic [SAMPLE_BITS-1:0] diff;
  logic [SW:0]            sum_ext;
  logic [SW-1:0]          sum_sat;
  logic [SW-1:0]          acc;
  logic                   cnt_below;
  logic [31:0]            idx_ext;

  // Absolute difference and saturating accumulate.
  always_comb begin
    diff      = (qbin_i > sample_i) ? (qbin_i - sample_i) : (sample_i - qbin_i);
    sum_ext   = {1'b0, run_q} + (SW + 1)'(diff);
    sum_sat   = sum_ext[SW] ? gsnm_pkg::SUM_MAX : sum_ext[SW-1:0];
    acc       = step_i.in_range ? sum_sat : run_q;
    cnt_below = cnt_q < CW'(MAX_REFS);
  end

  // Search state update.
  always_comb begin
    run_d     = run_q;
    best_d    = best_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    found_d   = found_q;
    res_vld_o = 1'b0;
    if (go_i) begin
      case (step_i.func)
        gsnm_pkg::FUNC_SAMPLE: begin
          if (step_i.last) begin
            run_d = '0;
            if (cnt_below) begin
              if (step_i.gate_ok && (!found_q || acc < best_q)) begin
                best_d  = acc;
                idx_d   = cnt_q;
                found_d = 1'b1;
              end
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            run_d = acc;
          end
        end
        gsnm_pkg::FUNC_REPORT: begin
          res_vld_o = 1'b1;
          run_d     = '0;
          best_d    = '0;
          cnt_d     = '0;
          idx_d     = '0;
          found_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Report fields read as zero when nothing passed the gate.
  always_comb begin
    idx_ext           = 32'(idx_q);
    res_o.match_found = found_q;
    res_o.best_entry  = found_q ? idx_ext[gsnm_pkg::ENTRY_W-1:0] : '0;
    res_o.best_score  = found_q ? best_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      best_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      run_q   <= run_d;
      best_q  <= best_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

endmodule
